>>> hdl/buq_pkg.sv
package buq_pkg;

  localparam int unsigned DepthDefault = 512;
  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    CmdHostWrite = 2'd0,
    CmdHostRead  = 2'd1,
    CmdLineRx    = 2'd2,
    CmdDre       = 2'd3
  } cmd_e;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_status_t;

endpackage

>>> hdl/buffered_uart_byte_queues.sv
// Receive and transmit byte rings of one uart channel, DEPTH slots each with one
// slot kept free. A command is taken in every clock cycle (busy never rises, no
// clearing pass after reset) and its result shows for one cycle under done_o in
// the cycle right after acceptance; that delay is set by the registered
// read port of the ring memories. The receiver cannot stall, so results must be
// captured when done_o is high.
module buffered_uart_byte_queues #(
  parameter int unsigned DEPTH = buq_pkg::DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd_i,
  input  logic [buq_pkg::ByteW-1:0] data_in_i,
  output logic                      done_o,
  output logic [buq_pkg::ByteW-1:0] read_data_o,
  output logic                      send_valid_o,
  output logic [buq_pkg::ByteW-1:0] send_byte_o,
  output logic                      empty_irq_armed_o,
  output logic                      owner_notify_o
);

  buq_pkg::cmd_e         cmd;
  buq_pkg::ring_status_t rx_status, tx_status;
  logic [buq_pkg::ByteW-1:0] rx_rdata, tx_rdata;
  logic accept;
  logic rx_push, rx_pop, tx_push, tx_pop;
  logic irq_en_q, irq_en_d;
  logic done_q, rx_pop_q, tx_pop_q, notify_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = buq_pkg::cmd_e'(cmd_i);

  always_comb begin
    rx_push  = 1'b0;
    rx_pop   = 1'b0;
    tx_push  = 1'b0;
    tx_pop   = 1'b0;
    irq_en_d = irq_en_q;
    if (accept) begin
      unique case (cmd)
        buq_pkg::CmdHostWrite: begin
          tx_push  = 1'b1;
          irq_en_d = 1'b1;
        end
        buq_pkg::CmdHostRead: begin
          rx_pop = 1'b1;
        end
        buq_pkg::CmdLineRx: begin
          rx_push = 1'b1;
        end
        buq_pkg::CmdDre: begin
          // armed: send one byte, or disarm when nothing is left
          if (irq_en_q) begin
            if (tx_status.empty) begin
              irq_en_d = 1'b0;
            end else begin
              tx_pop = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  buq_ring #(.DEPTH(DEPTH)) u_rx_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (rx_push),
    .pop_i    (rx_pop),
    .wdata_i  (data_in_i),
    .rdata_o  (rx_rdata),
    .status_o (rx_status)
  );

  buq_ring #(.DEPTH(DEPTH)) u_tx_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (tx_push),
    .pop_i    (tx_pop),
    .wdata_i  (data_in_i),
    .rdata_o  (tx_rdata),
    .status_o (tx_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= 1'b0;
      done_q   <= 1'b0;
      rx_pop_q <= 1'b0;
      tx_pop_q <= 1'b0;
      notify_q <= 1'b0;
    end else begin
      irq_en_q <= irq_en_d;
      done_q   <= accept;
      rx_pop_q <= rx_pop && !rx_status.empty;
      tx_pop_q <= tx_pop;
      notify_q <= rx_push;
    end
  end

  assign done_o            = done_q;
  assign read_data_o       = rx_pop_q ? rx_rdata : '0;
  assign send_valid_o      = tx_pop_q;
  assign send_byte_o       = tx_pop_q ? tx_rdata : '0;
  assign empty_irq_armed_o = irq_en_q;
  assign owner_notify_o    = notify_q;

`ifndef SYNTHESIS
  a_quiet_without_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (read_data_o == '0) && !send_valid_o && !owner_notify_o)
    else $error("result fields active without done strobe");

  a_send_keeps_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_valid_o |-> empty_irq_armed_o)
    else $error("byte sent while interrupt disarmed");

  a_arm_on_host_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_irq_armed_o) |-> $past(accept && (cmd == buq_pkg::CmdHostWrite)))
    else $error("interrupt armed without host write");

  a_disarm_on_dre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty_irq_armed_o) |-> $past(accept && (cmd == buq_pkg::CmdDre)
                                       && tx_status.empty))
    else $error("interrupt disarmed outside empty data register event");
`endif

endmodule

>>> hdl/buq_ring.sv
module buq_ring #(
  parameter int unsigned DEPTH = buq_pkg::DepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       pop_i,
  input  logic [buq_pkg::ByteW-1:0]  wdata_i,
  output logic [buq_pkg::ByteW-1:0]  rdata_o,
  output buq_pkg::ring_status_t      status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [buq_pkg::ByteW-1:0] mem [DEPTH];
  logic [buq_pkg::ByteW-1:0] rdata_q;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] wr_next, rd_next;
  logic          do_push, do_pop;

  // wrap at DEPTH-1, depth need not be a power of two
  assign wr_next = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
  assign rd_next = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);

  assign status_o.empty = (wr_ptr_q == rd_ptr_q);
  assign status_o.full  = (wr_next == rd_ptr_q);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_next : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_next : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> verif/tb_buffered_uart_byte_queues.sv
module tb_buffered_uart_byte_queues;
  import buq_pkg::*;

  localparam int unsigned Depth = DepthDefault;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             send_valid;
    logic [ByteW-1:0] send_byte;
    logic             irq_armed;
    logic             notify;
  } uart_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       cmd_i;
  logic [ByteW-1:0] data_in_i;
  logic             done_o;
  logic [ByteW-1:0] read_data_o;
  logic             send_valid_o;
  logic [ByteW-1:0] send_byte_o;
  logic             empty_irq_armed_o;
  logic             owner_notify_o;

  buffered_uart_byte_queues #(
    .DEPTH(Depth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .data_in_i        (data_in_i),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .send_valid_o     (send_valid_o),
    .send_byte_o      (send_byte_o),
    .empty_irq_armed_o(empty_irq_armed_o),
    .owner_notify_o   (owner_notify_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of both rings and the interrupt enable
  logic [ByteW-1:0] rx_ring [Depth];
  logic [ByteW-1:0] tx_ring [Depth];
  logic [PtrW-1:0]  rx_wr, rx_rd, tx_wr, tx_rd;
  logic             irq_armed;

  uart_result_t pending_responses[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;

  function automatic logic [PtrW-1:0] ring_adv(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic uart_result_t compute_uart_response(cmd_e c, logic [ByteW-1:0] d);
    uart_result_t r;
    r = '0;
    case (c)
      CmdHostWrite: begin
        // byte dropped on a full ring, interrupt armed regardless
        if (ring_adv(tx_wr) != tx_rd) begin
          tx_ring[tx_wr] = d;
          tx_wr = ring_adv(tx_wr);
        end
        irq_armed = 1'b1;
      end
      CmdHostRead: begin
        if (rx_wr != rx_rd) begin
          r.read_data = rx_ring[rx_rd];
          rx_rd = ring_adv(rx_rd);
        end
      end
      CmdLineRx: begin
        if (ring_adv(rx_wr) != rx_rd) begin
          rx_ring[rx_wr] = d;
          rx_wr = ring_adv(rx_wr);
        end
        r.notify = 1'b1;
      end
      default: begin
        if (irq_armed) begin
          if (tx_wr == tx_rd) begin
            irq_armed = 1'b0;
          end else begin
            r.send_valid = 1'b1;
            r.send_byte = tx_ring[tx_rd];
            tx_rd = ring_adv(tx_rd);
          end
        end
      end
    endcase
    r.irq_armed = irq_armed;
    return r;
  endfunction

  function automatic void note_mismatch(string what, uart_result_t want, uart_result_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display({"%s: exp rd=%02h sv=%0b sb=%02h arm=%0b ntf=%0b,",
                " got rd=%02h sv=%0b sb=%02h arm=%0b ntf=%0b"},
               what, want.read_data, want.send_valid, want.send_byte, want.irq_armed, want.notify,
               got.read_data, got.send_valid, got.send_byte, got.irq_armed, got.notify);
    end
  endfunction

  // one beat: optional idle gap, then hold start until accepted
  task automatic send_beat(cmd_e c, logic [ByteW-1:0] d);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    data_in_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_responses.push_back(compute_uart_response(c, d));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    uart_result_t got;
    uart_result_t want;
    if (rst_ni && done_o) begin
      got = {read_data_o, send_valid_o, send_byte_o, empty_irq_armed_o, owner_notify_o};
      if (pending_responses.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_disarmed_and_empty();
    send_beat(CmdDre, 8'h00);
    send_beat(CmdHostRead, 8'hff);
    send_beat(CmdDre, 8'haa);
  endtask

  task automatic test_transmit_path();
    send_beat(CmdHostWrite, 8'h00);
    send_beat(CmdHostWrite, 8'hff);
    send_beat(CmdDre, 8'h00);
    send_beat(CmdDre, 8'hff);
    // empty ring disarms, then the next event is ignored
    send_beat(CmdDre, 8'h00);
    send_beat(CmdDre, 8'h00);
    send_beat(CmdHostWrite, 8'h5a);
    send_beat(CmdDre, 8'h00);
    send_beat(CmdDre, 8'h00);
    send_beat(CmdDre, 8'h00);
  endtask

  task automatic test_receive_path();
    send_beat(CmdLineRx, 8'hff);
    send_beat(CmdLineRx, 8'h00);
    send_beat(CmdLineRx, 8'h81);
    send_beat(CmdHostRead, 8'h00);
    send_beat(CmdHostRead, 8'h00);
    send_beat(CmdHostRead, 8'h00);
    send_beat(CmdHostRead, 8'h00);
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct);
    int unsigned fill_pct;
    bit          produce;
    send_idle_pct = idle_pct;
    fill_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      // bursts that lean toward filling or draining the rings
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: fill_pct = 75;
          1: fill_pct = 25;
          default: fill_pct = 50;
        endcase
      end
      produce = ($urandom_range(0, 99) < fill_pct);
      if (produce) begin
        send_beat($urandom_range(0, 1) ? CmdLineRx : CmdHostWrite,
                  ByteW'($urandom_range(0, 255)));
      end else begin
        send_beat($urandom_range(0, 1) ? CmdDre : CmdHostRead,
                  ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    start = 1'b0;
    cmd_i = CmdHostWrite;
    data_in_i = '0;
    rst_ni = 1'b0;
    rx_wr = '0;
    rx_rd = '0;
    tx_wr = '0;
    tx_rd = '0;
    irq_armed = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 11;
    test_disarmed_and_empty();
    test_transmit_path();
    test_receive_path();
    test_random_traffic(160, 11);
    test_random_traffic(160, 72);
    test_random_traffic(160, 0);
    start <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      if (mismatches < MaxReports) $display("%0d results never arrived", pending_responses.size());
      mismatches += pending_responses.size();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/buq_pkg.sv
hdl/buq_ring.sv
hdl/buffered_uart_byte_queues.sv
verif/tb_buffered_uart_byte_queues.sv
